// ===== rtl/core/assert_macros.svh =====
// assertion helpers for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property on every rising edge of clk outside reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// check that a condition never holds on a rising edge of clk outside reset
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== rtl/core/ipts_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipts_pkg
// Types and codes of the inner product top-k search block.
// ----------------------------------------------------------------------------
package ipts_pkg;

    localparam logic [1:0] CMD_STORE = 2'd0;
    localparam logic [1:0] CMD_QUERY = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    localparam logic [1:0] ST_MATCH      = 2'd0;
    localparam logic [1:0] ST_NO_VECTORS = 2'd1;
    localparam logic [1:0] ST_STORED     = 2'd2;
    localparam logic [1:0] ST_FULL       = 2'd3;

    localparam logic       REG_LENGTH = 1'b0;
    localparam logic       REG_COUNT  = 1'b1;

    localparam int SCORE_W = 40;

    typedef struct packed {
        logic [1:0]         cmd;
        logic signed [15:0] element_value;
    } in_item_t;

    typedef struct packed {
        logic [9:0]                 vector_index;
        logic signed [SCORE_W-1:0]  match_score;
        logic [1:0]                 status;
        logic                       last_result;
    } out_item_t;

    typedef struct packed {
        logic take;
        logic rd_en;
        logic ins;
        logic emit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic scan_start;
        logic emit_last;
    } dp_stat_t;

endpackage

// ===== rtl/core/inner_product_topk_search.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// inner_product_topk_search
// Exact inner product top-k search over a store of Q1.15 vectors.
// ----------------------------------------------------------------------------
// Usage: an item is taken when start is high and busy low. Store and query
// items carry one element each. A completed store vector gives one
// stored/full result the next cycle; a completed query against an empty
// store gives one no_vectors result the next cycle. A completed query
// against N stored vectors raises busy for a scan of each vector (one
// element per cycle through the single store read port and MAC, then the
// pipeline drain and an insert), then emits up to result_count matches
// through the result register, best first, last marked, the last as busy
// falls. Each result shows on result for one cycle with result_valid high;
// the receiver cannot stall it. Configuration writes land at once via
// cfg_we; the user must make them only while idle, as the block does not
// enforce it. Reset empties the store and restores vector_length 256 and
// result_count 4; store memory itself is not cleared.
// ----------------------------------------------------------------------------
module inner_product_topk_search #(
    parameter int MAX_VECTORS = 1024,
    parameter int MAX_LENGTH  = 256,
    parameter int MAX_RESULTS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  ipts_pkg::in_item_t   item,
    input  logic                 cfg_we,
    input  logic                 cfg_index,
    input  logic [8:0]           cfg_data,
    output logic                 result_valid,
    output ipts_pkg::out_item_t  result
);

    localparam int IW   = (MAX_VECTORS > 1) ? $clog2(MAX_VECTORS) : 1;
    localparam int PW   = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
    localparam int LENW = $clog2(MAX_LENGTH + 1) + 1;
    localparam int CNTW = $clog2(MAX_VECTORS + 1) + 1;
    localparam int KIW  = (MAX_RESULTS > 1) ? $clog2(MAX_RESULTS) : 1;

    ipts_pkg::ctrl_cmd_t cmd;
    ipts_pkg::dp_stat_t  stat;
    logic [IW-1:0]   vec;
    logic [PW-1:0]   elem;
    logic [KIW-1:0]  emit_idx;
    logic [LENW-1:0] eff_len;
    logic [CNTW-1:0] n_vec;

    ipts_ctrl #(
        .IW(IW), .PW(PW), .LENW(LENW), .CNTW(CNTW), .KIW(KIW)
    ) u_ctrl (
        .clk(clk), .rst_n(rst_n), .start(start), .stat(stat),
        .eff_len(eff_len), .n_vec(n_vec), .cmd(cmd), .vec(vec),
        .elem(elem), .emit_idx(emit_idx), .busy(busy)
    );

    ipts_datapath #(
        .MAX_VECTORS(MAX_VECTORS), .MAX_LENGTH(MAX_LENGTH),
        .MAX_RESULTS(MAX_RESULTS), .IW(IW), .PW(PW), .LENW(LENW),
        .CNTW(CNTW), .KIW(KIW)
    ) u_dp (
        .clk(clk), .rst_n(rst_n), .item(item), .cfg_we(cfg_we),
        .cfg_index(cfg_index), .cfg_data(cfg_data), .cmd(cmd), .vec(vec),
        .elem(elem), .emit_idx(emit_idx), .stat(stat), .eff_len(eff_len),
        .n_vec(n_vec), .result_valid(result_valid), .result(result)
    );

endmodule

// ===== rtl/core/ipts_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipts_ctrl
// Sequencer for the scan: element reads, pipeline drain, insert, emit.
// ----------------------------------------------------------------------------
module ipts_ctrl #(
    parameter int IW   = 10,
    parameter int PW   = 8,
    parameter int LENW = 9,
    parameter int CNTW = 11,
    parameter int KIW  = 4
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  ipts_pkg::dp_stat_t    stat,
    input  logic [LENW-1:0]       eff_len,
    input  logic [CNTW-1:0]       n_vec,
    output ipts_pkg::ctrl_cmd_t   cmd,
    output logic [IW-1:0]         vec,
    output logic [PW-1:0]         elem,
    output logic [KIW-1:0]        emit_idx,
    output logic                  busy
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_DR1  = 3'd2;
    localparam logic [2:0] S_DR2  = 3'd3;
    localparam logic [2:0] S_INS  = 3'd4;
    localparam logic [2:0] S_EM   = 3'd5;

    logic [2:0]     state_reg, state_next;
    logic [IW-1:0]  vec_reg, vec_next;
    logic [PW-1:0]  elem_reg, elem_next;
    logic [KIW-1:0] em_reg, em_next;

    always_comb
    begin
        state_next = state_reg;
        vec_next   = vec_reg;
        elem_next  = elem_reg;
        em_next    = em_reg;
        cmd        = '0;
        cmd.take   = start && (state_reg == S_IDLE);
        unique case (state_reg)
            S_IDLE:
            begin
                if (stat.scan_start)
                begin
                    state_next = S_RD;
                    vec_next   = '0;
                    elem_next  = '0;
                end
            end
            S_RD:
            begin
                cmd.rd_en = 1'b1;
                if (LENW'(elem_reg) + LENW'(1) == eff_len)
                begin
                    elem_next  = '0;
                    state_next = S_DR1;
                end
                else
                begin
                    elem_next = elem_reg + PW'(1);
                end
            end
            S_DR1: state_next = S_DR2;
            S_DR2: state_next = S_INS;
            S_INS:
            begin
                cmd.ins = 1'b1;
                if (CNTW'(vec_reg) + CNTW'(1) == n_vec)
                begin
                    em_next    = '0;
                    state_next = S_EM;
                end
                else
                begin
                    vec_next   = vec_reg + IW'(1);
                    state_next = S_RD;
                end
            end
            S_EM:
            begin
                cmd.emit = 1'b1;
                if (stat.emit_last)
                    state_next = S_IDLE;
                else
                    em_next = em_reg + KIW'(1);
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            vec_reg   <= '0;
            elem_reg  <= '0;
            em_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            vec_reg   <= vec_next;
            elem_reg  <= elem_next;
            em_reg    <= em_next;
        end
    end

    assign vec      = vec_reg;
    assign elem     = elem_reg;
    assign emit_idx = em_reg;
    assign busy     = (state_reg != S_IDLE);

endmodule

// ===== rtl/core/ipts_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipts_datapath
// Vector store, query buffer, MAC pipeline, sorted best list, result register.
// ----------------------------------------------------------------------------
module ipts_datapath #(
    parameter int MAX_VECTORS = 1024,
    parameter int MAX_LENGTH  = 256,
    parameter int MAX_RESULTS = 16,
    parameter int IW   = 10,
    parameter int PW   = 8,
    parameter int LENW = 9,
    parameter int CNTW = 11,
    parameter int KIW  = 4
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  ipts_pkg::in_item_t    item,
    input  logic                  cfg_we,
    input  logic                  cfg_index,
    input  logic [8:0]            cfg_data,
    input  ipts_pkg::ctrl_cmd_t   cmd,
    input  logic [IW-1:0]         vec,
    input  logic [PW-1:0]         elem,
    input  logic [KIW-1:0]        emit_idx,
    output ipts_pkg::dp_stat_t    stat,
    output logic [LENW-1:0]       eff_len,
    output logic [CNTW-1:0]       n_vec,
    output logic                  result_valid,
    output ipts_pkg::out_item_t   result
);

    localparam int DEPTH = MAX_VECTORS * MAX_LENGTH;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int KW    = $clog2(MAX_RESULTS + 1);
    localparam int ACC_W = (33 + $clog2(MAX_LENGTH) > ipts_pkg::SCORE_W) ?
                           33 + $clog2(MAX_LENGTH) : ipts_pkg::SCORE_W;
    localparam int SW    = ipts_pkg::SCORE_W;

    localparam logic signed [SW-1:0] SCORE_HI = {1'b0, {(SW-1){1'b1}}};
    localparam logic signed [SW-1:0] SCORE_LO = {1'b1, {(SW-1){1'b0}}};

    logic [8:0]  len_cfg_reg;
    logic [4:0]  cnt_cfg_reg;
    logic [KW-1:0] eff_k;

    logic [PW-1:0]   spos_reg, qpos_reg;
    logic [CNTW-1:0] nvec_reg;

    logic signed [15:0] store_mem [DEPTH];
    logic signed [15:0] query_mem [MAX_LENGTH];
    logic signed [15:0] s_rd_reg, q_rd_reg;
    logic               v1_reg, v2_reg;
    logic signed [31:0] prod_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [SW-1:0]    score;

    logic                 valid_reg [MAX_RESULTS];
    logic signed [SW-1:0] best_reg  [MAX_RESULTS];
    logic [IW-1:0]        bidx_reg  [MAX_RESULTS];
    logic [MAX_RESULTS:0] vext;
    logic [MAX_RESULTS-1:0] above;

    logic full, store_done, query_done, take_store, take_query;
    logic [AW-1:0] wr_addr, rd_addr;

    always_comb
    begin
        if (len_cfg_reg == 9'd0)
            eff_len = LENW'(1);
        else if (int'(len_cfg_reg) > MAX_LENGTH)
            eff_len = LENW'(MAX_LENGTH);
        else
            eff_len = LENW'(len_cfg_reg);
        if (cnt_cfg_reg == 5'd0)
            eff_k = KW'(1);
        else if (int'(cnt_cfg_reg) > MAX_RESULTS)
            eff_k = KW'(MAX_RESULTS);
        else
            eff_k = KW'(cnt_cfg_reg);
    end

    assign take_store = cmd.take && (item.cmd == ipts_pkg::CMD_STORE);
    assign take_query = cmd.take && (item.cmd == ipts_pkg::CMD_QUERY);
    assign full       = (nvec_reg == CNTW'(MAX_VECTORS));
    assign store_done = (LENW'(spos_reg) + LENW'(1) >= eff_len);
    assign query_done = (LENW'(qpos_reg) + LENW'(1) >= eff_len);
    assign n_vec      = nvec_reg;

    assign stat.scan_start = take_query && query_done && (nvec_reg != '0);

    assign wr_addr = AW'(nvec_reg) * AW'(MAX_LENGTH) + AW'(spos_reg);
    assign rd_addr = AW'(vec) * AW'(MAX_LENGTH) + AW'(elem);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_cfg_reg <= 9'd256;
            cnt_cfg_reg <= 5'd4;
            spos_reg    <= '0;
            qpos_reg    <= '0;
            nvec_reg    <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == ipts_pkg::REG_LENGTH)
                    len_cfg_reg <= cfg_data;
                else
                    cnt_cfg_reg <= cfg_data[4:0];
            end
            if (take_store)
            begin
                if (store_done)
                begin
                    spos_reg <= '0;
                    if (!full)
                        nvec_reg <= nvec_reg + CNTW'(1);
                end
                else
                    spos_reg <= spos_reg + PW'(1);
            end
            if (take_query)
                qpos_reg <= query_done ? '0 : qpos_reg + PW'(1);
            if (cmd.take && (item.cmd == ipts_pkg::CMD_CLEAR))
            begin
                nvec_reg <= '0;
                spos_reg <= '0;
            end
        end
    end

    // memories
    always_ff @(posedge clk)
    begin
        if (take_store && !full)
            store_mem[wr_addr] <= item.element_value;
        if (take_query)
            query_mem[qpos_reg] <= item.element_value;
        s_rd_reg <= store_mem[rd_addr];
        q_rd_reg <= query_mem[elem];
    end

    // MAC pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= cmd.rd_en;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= s_rd_reg * q_rd_reg;
        if (cmd.ins || stat.scan_start)
            acc_reg <= '0;
        else if (v2_reg)
            acc_reg <= acc_reg + ACC_W'(prod_reg);
    end

    always_comb
    begin
        if (acc_reg > ACC_W'(SCORE_HI))
            score = SCORE_HI;
        else if (acc_reg < ACC_W'(SCORE_LO))
            score = SCORE_LO;
        else
            score = SW'(acc_reg);
    end

    // sorted best list, parallel insert
    always_comb
    begin
        for (int j = 0; j < MAX_RESULTS; j++)
        begin
            above[j]  = valid_reg[j] && !(score > best_reg[j]);
            vext[j]   = valid_reg[j];
        end
        vext[MAX_RESULTS] = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < MAX_RESULTS; j++)
                valid_reg[j] <= 1'b0;
        end
        else if (stat.scan_start)
        begin
            for (int j = 0; j < MAX_RESULTS; j++)
                valid_reg[j] <= 1'b0;
        end
        else if (cmd.ins)
        begin
            for (int j = 0; j < MAX_RESULTS; j++)
                if (j < int'(eff_k))
                    valid_reg[j] <= valid_reg[j] || (j == 0) || valid_reg[(j == 0) ? 0 : j-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ins)
        begin
            for (int j = 0; j < MAX_RESULTS; j++)
            begin
                if (j < int'(eff_k) && !above[j])
                begin
                    if (j == 0 || above[(j == 0) ? 0 : j-1])
                    begin
                        best_reg[j] <= score;
                        bidx_reg[j] <= vec;
                    end
                    else
                    begin
                        best_reg[j] <= best_reg[(j == 0) ? 0 : j-1];
                        bidx_reg[j] <= bidx_reg[(j == 0) ? 0 : j-1];
                    end
                end
            end
        end
    end

    assign stat.emit_last = !vext[(KIW+1)'(emit_idx) + (KIW+1)'(1)];

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid <= 1'b0;
        else
            result_valid <= (take_store && store_done)
                         || (take_query && query_done && nvec_reg == '0)
                         || cmd.emit;
    end

    always_ff @(posedge clk)
    begin
        result.match_score  <= '0;
        result.last_result  <= 1'b1;
        result.vector_index <= '0;
        if (cmd.emit)
        begin
            result.vector_index <= 10'(bidx_reg[emit_idx]);
            result.match_score  <= best_reg[emit_idx];
            result.status       <= ipts_pkg::ST_MATCH;
            result.last_result  <= stat.emit_last;
        end
        else if (take_store)
        begin
            result.status <= full ? ipts_pkg::ST_FULL : ipts_pkg::ST_STORED;
            if (!full)
                result.vector_index <= 10'(nvec_reg);
        end
        else
            result.status <= ipts_pkg::ST_NO_VECTORS;
    end

endmodule

// ===== rtl/core/ipts_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipts_checker
// Port-level checks of the inner product top-k search block.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ipts_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                start,
    input logic                busy,
    input logic                result_valid,
    input ipts_pkg::out_item_t result
);

    logic is_status, is_match, is_stored, is_full;

    assign is_status = result_valid && (result.status != ipts_pkg::ST_MATCH);
    assign is_match  = result_valid && (result.status == ipts_pkg::ST_MATCH);
    assign is_stored = result_valid && (result.status == ipts_pkg::ST_STORED);
    assign is_full   = result_valid && (result.status == ipts_pkg::ST_FULL);

    `ASSERT_CLK(a_status_last, is_status |-> result.last_result, "status item without last mark")
    `ASSERT_CLK(a_status_zero, is_status |-> (result.match_score == '0), "status item with score")
    `ASSERT_CLK(a_match_scan, is_match |-> $past(busy), "match outside scan")
    `ASSERT_CLK(a_stored_take, is_stored |-> $past(start && !busy), "stored without item")
    `ASSERT_NEVER(a_full_index, is_full && (result.vector_index != '0), "full item with index")

endmodule

bind inner_product_topk_search ipts_checker u_ipts_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .result_valid(result_valid), .result(result)
);
